// ----- hdl/sem_pkg.sv -----
// ----------------------------------------------------------------------------
// sem_pkg: shared types and constants for the sobel edge magnitude block
// Field widths, register indexes, reset values and the window column type.
// ----------------------------------------------------------------------------
`default_nettype none

package sem_pkg;

    localparam int MAX_WIDTH_DEF = 1024;

    localparam int PIX_W      = 8;
    localparam int FW_W       = 11;
    localparam int FH_W       = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 1;

    localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 11'd640;
    localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 16'd480;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'd1;

    // signed gradient sum, |sum| <= 1020
    localparam int SUM_W = 11;

    localparam int SKID_DEPTH = 4;
    localparam int SKID_PTR_W = 2;
    localparam int SKID_CNT_W = 3;

    typedef struct packed {
        logic [PIX_W-1:0] top;
        logic [PIX_W-1:0] mid;
        logic [PIX_W-1:0] bot;
    } t_column;

    typedef struct packed {
        logic valid;
        logic last;
    } t_flags;

endpackage

`default_nettype wire

// ----- hdl/sem_line_store.sv -----
// ----------------------------------------------------------------------------
// sem_line_store: row store for the two rows above the current one
// One write and one registered read per cycle; a read of the address being
// written in the same cycle returns the new data.
// ----------------------------------------------------------------------------
`default_nettype none

module sem_line_store #(
    parameter int DEPTH  = sem_pkg::MAX_WIDTH_DEF,
    parameter int DATA_W = 2 * sem_pkg::PIX_W
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [DATA_W-1:0]        i_wdata,
    output logic      [DATA_W-1:0]        o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            if (i_we && (i_waddr == i_raddr)) begin
                r_rdata <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_raddr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- hdl/sem_col_cell.sv -----
// ----------------------------------------------------------------------------
// sem_col_cell: one column of the 3x3 window
// Holds top, middle and bottom pixel and passes them to the next cell on shift.
// ----------------------------------------------------------------------------
`default_nettype none

module sem_col_cell (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_shift,
    input  wire sem_pkg::t_column i_col,
    output sem_pkg::t_column     o_col
);

    sem_pkg::t_column r_col;
    sem_pkg::t_column n_col;

    always_comb begin
        n_col = r_col;
        if (i_shift) begin
            n_col = i_col;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
        end else begin
            r_col <= n_col;
        end
    end

    assign o_col = r_col;

endmodule

`default_nettype wire

// ----- hdl/sem_grad.sv -----
// ----------------------------------------------------------------------------
// sem_grad: sobel gradient sums and magnitude
// Registers the horizontal and vertical sums of the window, then forms
// |sumh|/8 + |sumv|/8 from the registered sums.
// ----------------------------------------------------------------------------
`default_nettype none

module sem_grad (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire sem_pkg::t_column i_left,
    input  wire sem_pkg::t_column i_center,
    input  wire sem_pkg::t_column i_right,
    input  wire sem_pkg::t_flags  i_flags,
    output sem_pkg::t_flags       o_flags,
    output logic [sem_pkg::PIX_W-1:0] o_edge_value
);

    localparam int WS_W  = sem_pkg::PIX_W + 2;
    localparam int MAG_W = sem_pkg::SUM_W - 3;

    // x + 2y + z
    function automatic logic [WS_W-1:0] wsum(
        input logic [sem_pkg::PIX_W-1:0] x,
        input logic [sem_pkg::PIX_W-1:0] y,
        input logic [sem_pkg::PIX_W-1:0] z
    );
        return WS_W'(x) + {1'b0, y, 1'b0} + WS_W'(z);
    endfunction

    function automatic logic [MAG_W-1:0] mag8(input logic signed [sem_pkg::SUM_W-1:0] s);
        logic [sem_pkg::SUM_W-1:0] a;
        a = s[sem_pkg::SUM_W-1] ? sem_pkg::SUM_W'(-s) : sem_pkg::SUM_W'(s);
        return a[sem_pkg::SUM_W-1:3];
    endfunction

    logic signed [sem_pkg::SUM_W-1:0] r_sumh;
    logic signed [sem_pkg::SUM_W-1:0] r_sumv;
    logic signed [sem_pkg::SUM_W-1:0] n_sumh;
    logic signed [sem_pkg::SUM_W-1:0] n_sumv;
    sem_pkg::t_flags                  r_flags;

    always_comb begin
        n_sumh = $signed(sem_pkg::SUM_W'(wsum(i_right.top, i_right.mid, i_right.bot)))
               - $signed(sem_pkg::SUM_W'(wsum(i_left.top, i_left.mid, i_left.bot)));
        n_sumv = $signed(sem_pkg::SUM_W'(wsum(i_left.bot, i_center.bot, i_right.bot)))
               - $signed(sem_pkg::SUM_W'(wsum(i_left.top, i_center.top, i_right.top)));
    end

    always_ff @(posedge i_clk) begin
        r_sumh <= n_sumh;
        r_sumv <= n_sumv;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags <= '0;
        end else begin
            r_flags <= i_flags;
        end
    end

    assign o_flags      = r_flags;
    assign o_edge_value = sem_pkg::PIX_W'(mag8(r_sumh)) + sem_pkg::PIX_W'(mag8(r_sumv));

endmodule

`default_nettype wire

// ----- hdl/sobel_edge_magnitude_3x3.sv -----
// ----------------------------------------------------------------------------
// sobel_edge_magnitude_3x3: streaming 3x3 sobel edge magnitude
// Throughput: one pixel request per cycle unless o_stall is high, set by the
// line store, which does one read and one write per cycle. Results pass stage
// a, the gradient registers and a four-entry output skid queue to the output.
// Reset: synchronous; 640x480 frame, position row 0 column 0, window zero;
// line store contents are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module sobel_edge_magnitude_3x3 #(
    parameter int MAX_WIDTH = sem_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [sem_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [sem_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  wire logic                              i_valid,
    output logic                                   o_stall,
    input  wire logic [sem_pkg::PIX_W-1:0]         i_pixel,
    input  wire logic                              i_frame_start,
    output logic                                   o_valid,
    input  wire logic                              i_stall,
    output logic [sem_pkg::PIX_W-1:0]              o_edge_value,
    output logic                                   o_frame_last
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int LW = ($clog2(MAX_WIDTH + 1) > sem_pkg::FW_W) ?
                        $clog2(MAX_WIDTH + 1) : sem_pkg::FW_W;
    localparam int PW = sem_pkg::PIX_W;
    localparam int HW = sem_pkg::FH_W;

    // configuration
    logic [sem_pkg::FW_W-1:0] r_width;
    logic [HW-1:0]            r_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= sem_pkg::FRAME_WIDTH_RST;
            r_height <= sem_pkg::FRAME_HEIGHT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                sem_pkg::CFG_FRAME_WIDTH:  r_width  <= i_cfg_data[sem_pkg::FW_W-1:0];
                sem_pkg::CFG_FRAME_HEIGHT: r_height <= i_cfg_data[HW-1:0];
                default: begin
                end
            endcase
        end
    end

    logic [LW-1:0] width_ext;
    logic [LW-1:0] w_last;
    logic [HW-1:0] h_last;

    always_comb begin
        width_ext = LW'(r_width);
        if (width_ext < LW'(3)) begin
            w_last = LW'(2);
        end else if (width_ext > LW'(MAX_WIDTH)) begin
            w_last = LW'(MAX_WIDTH - 1);
        end else begin
            w_last = width_ext - LW'(1);
        end
        if (r_height < HW'(3)) begin
            h_last = HW'(2);
        end else begin
            h_last = r_height - HW'(1);
        end
    end

    // position tracking at the input
    logic [CW-1:0] r_col;
    logic [HW-1:0] r_row;
    logic [CW-1:0] n_col;
    logic [HW-1:0] n_row;
    logic [CW-1:0] col_cur;
    logic [HW-1:0] row_cur;
    logic          accept;
    logic          row_end;
    logic          cur_emit;
    logic          cur_last;

    assign accept = i_valid && !o_stall;

    always_comb begin
        col_cur  = i_frame_start ? '0 : r_col;
        row_cur  = i_frame_start ? '0 : r_row;
        row_end  = LW'(col_cur) >= w_last;
        cur_emit = (row_cur >= HW'(2)) && (col_cur >= CW'(2));
        cur_last = (row_cur == h_last) && (LW'(col_cur) == w_last);
        n_col    = r_col;
        n_row    = r_row;
        if (accept) begin
            if (row_end) begin
                n_col = '0;
                n_row = (row_cur >= h_last) ? '0 : row_cur + HW'(1);
            end else begin
                n_col = col_cur + CW'(1);
                n_row = row_cur;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // stage a: line store read data arrives
    logic          r_a_valid;
    logic          r_a_emit;
    logic          r_a_last;
    logic [CW-1:0] r_a_col;
    logic [PW-1:0] r_a_pix;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_a_emit  <= 1'b0;
        end else begin
            r_a_valid <= accept;
            r_a_emit  <= accept && cur_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a_col  <= col_cur;
            r_a_pix  <= i_pixel;
            r_a_last <= cur_last;
        end
    end

    // upper byte: row above, lower byte: two rows above
    logic [2*PW-1:0] store_rdata;

    sem_line_store #(
        .DEPTH  (MAX_WIDTH),
        .DATA_W (2 * PW)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_re    (accept),
        .i_raddr (col_cur),
        .i_we    (r_a_valid),
        .i_waddr (r_a_col),
        .i_wdata ({r_a_pix, store_rdata[2*PW-1:PW]}),
        .o_rdata (store_rdata)
    );

    sem_pkg::t_column cur_column;
    sem_pkg::t_column near_column;
    sem_pkg::t_column far_column;

    always_comb begin
        cur_column.top = store_rdata[PW-1:0];
        cur_column.mid = store_rdata[2*PW-1:PW];
        cur_column.bot = r_a_pix;
    end

    sem_col_cell u_cell_near (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_shift (r_a_valid),
        .i_col   (cur_column),
        .o_col   (near_column)
    );

    sem_col_cell u_cell_far (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_shift (r_a_valid),
        .i_col   (near_column),
        .o_col   (far_column)
    );

    sem_pkg::t_flags a_flags;
    sem_pkg::t_flags g_flags;
    logic [PW-1:0]   g_edge;

    assign a_flags.valid = r_a_emit;
    assign a_flags.last  = r_a_last;

    sem_grad u_grad (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_left       (far_column),
        .i_center     (near_column),
        .i_right      (cur_column),
        .i_flags      (a_flags),
        .o_flags      (g_flags),
        .o_edge_value (g_edge)
    );

    // output skid queue
    logic [PW-1:0]                 r_q_val  [sem_pkg::SKID_DEPTH];
    logic                          r_q_last [sem_pkg::SKID_DEPTH];
    logic [sem_pkg::SKID_PTR_W-1:0] r_wr_ptr;
    logic [sem_pkg::SKID_PTR_W-1:0] r_rd_ptr;
    logic [sem_pkg::SKID_CNT_W-1:0] r_cnt;
    logic [sem_pkg::SKID_CNT_W-1:0] n_cnt;
    logic                          push;
    logic                          pop;
    logic [sem_pkg::SKID_CNT_W-1:0] pending;

    assign push = g_flags.valid;
    assign pop  = o_valid && !i_stall;

    always_comb begin
        n_cnt = r_cnt;
        if (push && !pop) begin
            n_cnt = r_cnt + sem_pkg::SKID_CNT_W'(1);
        end else if (!push && pop) begin
            n_cnt = r_cnt - sem_pkg::SKID_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (push) begin
                r_wr_ptr <= r_wr_ptr + sem_pkg::SKID_PTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + sem_pkg::SKID_PTR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q_val[r_wr_ptr]  <= g_edge;
            r_q_last[r_wr_ptr] <= g_flags.last;
        end
    end

    // room for every result still in flight
    assign pending = r_cnt + sem_pkg::SKID_CNT_W'(r_a_emit)
                   + sem_pkg::SKID_CNT_W'(g_flags.valid);
    assign o_stall = pending >= sem_pkg::SKID_CNT_W'(sem_pkg::SKID_DEPTH);

    assign o_valid      = r_cnt != '0;
    assign o_edge_value = r_q_val[r_rd_ptr];
    assign o_frame_last = r_q_last[r_rd_ptr];

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench for sobel_edge_magnitude_3x3
// Streams pixel planes of many sizes, with restarts, noise and mid-plane
// register changes, through the block under random input gaps and output
// stalls. A line store and window model predicts each edge result, and
// results are checked in order, field by field.
// ----------------------------------------------------------------------------
module tb_top;
    import sem_pkg::*;

    localparam int MAX_W          = MAX_WIDTH_DEF;
    localparam int RANDOM_ITEMS   = 1450;
    localparam int DRAIN_CYCLES   = 10;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_CYCLES    = 300;
    localparam int REPORT_MAX     = 10;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             frame_start;
    } pixel_req_t;

    typedef struct packed {
        logic [PIX_W-1:0] edge_value;
        logic             frame_last;
    } edge_result_t;

    typedef enum logic [1:0] {PX_UNIFORM, PX_EXTREME, PX_RAMP} px_mode_t;
    typedef enum logic [1:0] {RX_FREE, RX_RANDOM, RX_PERIODIC, RX_HEAVY} rx_mode_t;

    // dark left, bright right and bottom: strong positive gradients
    localparam logic [PIX_W-1:0] RISE_IMG [9] = '{
        8'd0, 8'd0, 8'd255, 8'd0, 8'd0, 8'd255, 8'd0, 8'd255, 8'd255};
    localparam logic [PIX_W-1:0] FALL_IMG [9] = '{
        8'd255, 8'd255, 8'd0, 8'd255, 8'd255, 8'd0, 8'd255, 8'd0, 8'd0};

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;
    logic                  i_valid       = 1'b0;
    logic [PIX_W-1:0]      i_pixel       = '0;
    logic                  i_frame_start = 1'b0;
    logic                  i_stall       = 1'b0;
    logic                  o_stall;
    logic                  o_valid;
    logic [PIX_W-1:0]      o_edge_value;
    logic                  o_frame_last;

    sobel_edge_magnitude_3x3 dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_pixel       (i_pixel),
        .i_frame_start (i_frame_start),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_edge_value  (o_edge_value),
        .o_frame_last  (o_frame_last)
    );

    pixel_req_t   pend_px[$];
    edge_result_t edge_q[$];

    // predictor state
    logic [PIX_W-1:0] store_above     [MAX_W];
    logic [PIX_W-1:0] store_two_above [MAX_W];
    t_column          older_col;
    t_column          newer_col;
    int unsigned      pred_col;
    int unsigned      pred_row;
    logic [FW_W-1:0]  cfg_w;
    logic [FH_W-1:0]  cfg_h;

    // sender and receiver state
    bit          took;
    int unsigned gap_left;
    int unsigned burst_left;
    rx_mode_t    rx_mode;
    int unsigned mode_left;
    int unsigned hold_left;
    bit          hold_done;
    int unsigned rx_tick;
    int unsigned quiet_cycles = 0;
    edge_result_t head_exp;

    // stimulus bookkeeping
    int unsigned cur_w;
    int unsigned cur_h;
    bit          cfg_fresh = 1'b0;
    logic [PIX_W-1:0] ramp_px = '0;

    int unsigned n_queued = 0;
    int unsigned n_pix    = 0;
    int unsigned n_res    = 0;
    int unsigned n_cfg    = 0;
    int unsigned n_segs   = 0;
    int unsigned errors   = 0;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic int unsigned clamp_width(logic [FW_W-1:0] v);
        if (v < 3) return 3;
        if (v > MAX_W) return MAX_W;
        return 32'(v);
    endfunction

    function automatic int unsigned clamp_height(logic [FH_W-1:0] v);
        return (v < 3) ? 3 : 32'(v);
    endfunction

    function automatic int mag_div8(int s);
        return ((s < 0) ? -s : s) / 8;
    endfunction

    function void report_fail(string msg);
        errors++;
        if (errors <= REPORT_MAX) $display("ERROR: %s", msg);
    endfunction

    function automatic logic [PIX_W-1:0] next_pixel(px_mode_t mode);
        case (mode)
            PX_EXTREME: return ($urandom_range(0, 1) != 0) ? 8'hff : 8'h00;
            PX_RAMP: begin
                ramp_px = ramp_px + PIX_W'($urandom_range(0, 24));
                return ramp_px;
            end
            default: return PIX_W'($urandom());
        endcase
    endfunction

    task automatic predict_edge(input pixel_req_t req);
        int unsigned  w, h, col;
        t_column      cur;
        int           a, b, c, d, f, g, hh, i, gh, gv;
        edge_result_t res;
        w = clamp_width(cfg_w);
        h = clamp_height(cfg_h);
        if (req.frame_start) begin
            pred_col = 0;
            pred_row = 0;
        end
        col = (pred_col >= MAX_W) ? MAX_W - 1 : pred_col;
        cur.top = store_two_above[col];
        cur.mid = store_above[col];
        cur.bot = req.pixel;
        if (pred_row >= 2 && col >= 2) begin
            a  = int'(older_col.top);
            d  = int'(older_col.mid);
            g  = int'(older_col.bot);
            b  = int'(newer_col.top);
            hh = int'(newer_col.bot);
            c  = int'(cur.top);
            f  = int'(cur.mid);
            i  = int'(cur.bot);
            gh = -a + c - 2 * d + 2 * f - g + i;
            gv = -a - 2 * b - c + g + 2 * hh + i;
            res.edge_value = PIX_W'(mag_div8(gh) + mag_div8(gv));
            res.frame_last = (pred_row == h - 1) && (col == w - 1);
            edge_q.push_back(res);
        end
        older_col = newer_col;
        newer_col = cur;
        store_two_above[col] = cur.mid;
        store_above[col]     = cur.bot;
        // a column at or past the last one ends the row, same for rows
        if (col >= w - 1) begin
            pred_col = 0;
            pred_row = (pred_row >= h - 1) ? 0 : pred_row + 1;
        end else begin
            pred_col = col + 1;
        end
    endtask

    // driver: feeds pixel requests in bursts and predicts on acceptance
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid    <= 1'b0;
            pred_col   = 0;
            pred_row   = 0;
            older_col  = '0;
            newer_col  = '0;
            cfg_w      = FRAME_WIDTH_RST;
            cfg_h      = FRAME_HEIGHT_RST;
            gap_left   = 0;
            burst_left = 0;
        end else begin
            took = i_valid && !o_stall;
            if (took) begin
                predict_edge(pend_px.pop_front());
                n_pix++;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_FRAME_WIDTH:  cfg_w = i_cfg_data[FW_W-1:0];
                    CFG_FRAME_HEIGHT: cfg_h = i_cfg_data[FH_W-1:0];
                    default: ;
                endcase
            end
            if (!i_valid || took) begin
                if (gap_left != 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (pend_px.size() != 0) begin
                    i_valid       <= 1'b1;
                    i_pixel       <= pend_px[0].pixel;
                    i_frame_start <= pend_px[0].frame_start;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = ($urandom_range(0, 3) == 0) ?
                                     $urandom_range(100, 300) : $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: checks results in order and drives the output stall
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall   <= 1'b0;
            rx_mode   = RX_FREE;
            mode_left = 0;
            hold_left = 0;
            hold_done = 1'b0;
            rx_tick   = 0;
        end else begin
            if (o_valid && !i_stall) begin
                n_res++;
                if (edge_q.size() == 0) begin
                    report_fail($sformatf("unexpected result edge_value=%0d frame_last=%0d",
                                          o_edge_value, o_frame_last));
                end else begin
                    head_exp = edge_q.pop_front();
                    if (o_edge_value !== head_exp.edge_value)
                        report_fail($sformatf("result %0d edge_value expected %0d got %0d",
                                              n_res, head_exp.edge_value, o_edge_value));
                    if (o_frame_last !== head_exp.frame_last)
                        report_fail($sformatf("result %0d frame_last expected %0d got %0d",
                                              n_res, head_exp.frame_last, o_frame_last));
                end
            end
            rx_tick++;
            if (hold_left != 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (!hold_done && pend_px.size() > 200) begin
                // long hold-off while the sender keeps offering requests
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                i_stall   <= 1'b1;
            end else begin
                if (mode_left == 0) begin
                    rx_mode   = rx_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(20, 300);
                end else begin
                    mode_left--;
                end
                case (rx_mode)
                    RX_FREE:     i_stall <= 1'b0;
                    RX_RANDOM:   i_stall <= ($urandom_range(0, 99) < 35);
                    RX_PERIODIC: i_stall <= ((rx_tick % 5) < 2);
                    default:     i_stall <= ($urandom_range(0, 99) < 80);
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("ERROR: no request moved for %0d cycles", WATCHDOG_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic wait_quiet();
        while (pend_px.size() != 0 || i_valid || edge_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic push_px(input logic [PIX_W-1:0] px, input logic fs);
        // first pixel after a register change starts a plane unless cfg_fresh is cleared
        pend_px.push_back('{pixel: px, frame_start: fs | cfg_fresh});
        cfg_fresh = 1'b0;
        n_queued++;
    endtask

    task automatic push_plane(input int unsigned n, input logic fs_first, input px_mode_t mode);
        for (int unsigned k = 0; k < n; k++)
            push_px(next_pixel(mode), (k == 0) ? fs_first : 1'b0);
        n_segs++;
    endtask

    task automatic write_frame_regs(input logic [FW_W-1:0] w, input logic [FH_W-1:0] h);
        logic [CFG_DATA_W-FW_W-1:0] upper;
        wait_quiet();
        upper = ($urandom_range(0, 3) == 0) ? (CFG_DATA_W-FW_W)'($urandom()) : '0;
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_FRAME_WIDTH;
        i_cfg_data  <= {upper, w};
        @(posedge i_clk);
        i_cfg_index <= CFG_FRAME_HEIGHT;
        i_cfg_data  <= h;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cur_w     = clamp_width(w);
        cur_h     = clamp_height(h);
        cfg_fresh = 1'b1;
        n_cfg += 2;
    endtask

    task automatic new_small_frame();
        logic [FW_W-1:0] w;
        logic [FH_W-1:0] h;
        w = ($urandom_range(0, 99) < 15) ? FW_W'($urandom_range(0, 2)) :
                                           FW_W'($urandom_range(3, 12));
        h = ($urandom_range(0, 99) < 15) ? FH_W'($urandom_range(0, 2)) :
                                           FH_W'($urandom_range(3, 7));
        write_frame_regs(w, h);
    endtask

    initial begin : stimulus
        int unsigned sel, n, lim, k, w, w2;
        bit          at_origin;
        px_mode_t    mode;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: 3x3 planes with extreme gradients, wrap and restart
        write_frame_regs(11'd3, 16'd3);
        for (int j = 0; j < 9; j++) push_px(RISE_IMG[j], j == 0);
        for (int j = 0; j < 9; j++) push_px(FALL_IMG[j], 1'b0);
        push_px(8'hff, 1'b1);
        push_px(8'h00, 1'b0);
        push_px(8'hff, 1'b0);
        push_px(8'h00, 1'b0);
        n_segs += 3;

        // a long run of small planes queued at once keeps the sender
        // offering requests through the output hold-off
        for (int j = 0; j < 27; j++)
            push_plane(9, j == 0, px_mode_t'($urandom_range(0, 2)));
        at_origin = 1'b1;

        while (n_queued < RANDOM_ITEMS) begin
            sel  = $urandom_range(0, 99);
            mode = px_mode_t'($urandom_range(0, 2));
            if (sel < 55) begin
                if (cur_w > 12 || cur_h > 8 || $urandom_range(0, 1) == 0)
                    new_small_frame();
                push_plane(cur_w * cur_h, !at_origin || ($urandom_range(0, 1) != 0), mode);
                at_origin = 1'b1;
            end else if (sel < 70) begin
                // plane cut short, a later frame start restarts it
                if (cur_w > 12 || $urandom_range(0, 2) == 0)
                    new_small_frame();
                lim = cur_w * cur_h - 1;
                if (lim > 80) lim = 80;
                push_plane($urandom_range(1, lim), 1'b1, mode);
                at_origin = 1'b0;
            end else if (sel < 80) begin
                // noise with stray frame starts
                if (cur_w > 12)
                    new_small_frame();
                n = $urandom_range(8, 40);
                for (int unsigned j = 0; j < n; j++)
                    push_px(next_pixel(mode), $urandom_range(0, 99) < 8);
                n_segs++;
                at_origin = 1'b0;
            end else if (sel < 90) begin
                // tall plane, only the first rows are sent
                w = $urandom_range(3, 6);
                write_frame_regs(FW_W'(w), ($urandom_range(0, 1) == 0) ?
                                 16'hffff : FH_W'($urandom_range(17, 65534)));
                push_plane(w * $urandom_range(3, 6), 1'b1, mode);
                at_origin = 1'b0;
            end else begin
                // the width register shrinks in the middle of a plane
                w = $urandom_range(6, 12);
                write_frame_regs(FW_W'(w), FH_W'($urandom_range(5, 8)));
                k = $urandom_range(3, w - 1);
                push_plane(3 * w + k, 1'b1, mode);
                w2 = $urandom_range(3, k);
                write_frame_regs(FW_W'(w2), FH_W'($urandom_range(0, 8)));
                // width only shrinks, so the line stores stay valid
                cfg_fresh = 1'b0;
                push_plane(1 + w2 * $urandom_range(1, 3), 1'b0, mode);
                at_origin = 1'b0;
            end
        end

        while (pend_px.size() != 0 || i_valid) @(posedge i_clk);
        for (int j = 0; j < 2000 && edge_q.size() != 0; j++) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (edge_q.size() != 0)
            report_fail($sformatf("%0d expected results never arrived", edge_q.size()));

        $display("run covered %0d pixel requests in %0d segments with %0d register writes",
                 n_pix, n_segs, n_cfg);
        $display("%0d edge results checked, %0d mismatches, long output hold-off %s",
                 n_res, errors, hold_done ? "applied" : "not reached");
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
